// ===== sv/assert_macros.svh =====
// Shared assertion macros for the debounce block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, skipped while reset is held.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// When ante holds, cons must hold on the same edge.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

`endif

// ===== sv/bdpe_pkg.sv =====
package bdpe_pkg;

    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE  = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SHORT_MAX = 8'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LONG      = 8'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_REPEAT    = 8'd3;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST  = 16'd15;
    localparam logic [CFG_W-1:0] SHORT_MAX_RST = 16'd1000;
    localparam logic [CFG_W-1:0] LONG_RST      = 16'd3000;
    localparam logic [CFG_W-1:0] REPEAT_RST    = 16'd200;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ticks;
        logic [CFG_W-1:0] short_max_ticks;
        logic [CFG_W-1:0] long_press_ticks;
        logic [CFG_W-1:0] repeat_ticks;
    } cfg_t;

    typedef struct packed {
        logic press_event;
        logic short_press_event;
        logic release_event;
        logic long_press_event;
        logic repeat_event;
        logic stable_out;
    } result_t;

endpackage

// ===== sv/bdpe_core.sv =====
module bdpe_core #(
    parameter int TIMER_BITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic             pin_level,
    input  bdpe_pkg::cfg_t   cfg,
    output bdpe_pkg::result_t result
);

    // compare width covers both the timers and the 16-bit settings
    localparam int CW = (TIMER_BITS > bdpe_pkg::CFG_W) ? TIMER_BITS : bdpe_pkg::CFG_W;

    logic                  raw_seen_reg,     raw_seen_next;
    logic                  settling_reg,     settling_next;
    logic [TIMER_BITS-1:0] settle_count_reg, settle_count_next;
    logic                  stable_reg,       stable_next;
    logic                  long_armed_reg,   long_armed_next;
    logic                  repeat_armed_reg, repeat_armed_next;
    logic [TIMER_BITS-1:0] press_reg,        press_next;
    logic [TIMER_BITS-1:0] repeat_reg,       repeat_next;

    logic                  changed, settling_1, fire, new_level;
    logic                  ev_press, ev_release, ev_short, ev_long, ev_repeat;
    logic                  long_arm_1, repeat_arm_1;
    logic [TIMER_BITS-1:0] settle_inc, press_inc, repeat_inc;
    logic [TIMER_BITS-1:0] settle_1, press_1, repeat_1;

    function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
        sat_inc = (&v) ? v : v + 1'b1;
    endfunction

    always_comb begin
        settle_inc = sat_inc(settle_count_reg);
        press_inc  = sat_inc(press_reg);
        repeat_inc = sat_inc(repeat_reg);

        changed    = (pin_level != raw_seen_reg);
        settling_1 = settling_reg | changed;
        settle_1   = changed ? '0 : settle_inc;

        fire       = settling_1 && (CW'(settle_1) >= CW'(cfg.debounce_ticks));
        new_level  = fire && (pin_level != stable_reg);
        ev_press   = new_level && !pin_level;
        ev_release = new_level && pin_level;
        ev_short   = ev_release && (CW'(press_inc) <= CW'(cfg.short_max_ticks));

        long_arm_1   = ev_press ? 1'b1 : (ev_release ? 1'b0 : long_armed_reg);
        repeat_arm_1 = ev_press ? 1'b1 : (ev_release ? 1'b0 : repeat_armed_reg);
        press_1      = ev_press ? '0 : press_inc;
        repeat_1     = ev_press ? '0 : repeat_inc;

        ev_long   = long_arm_1 && (CW'(press_1) >= CW'(cfg.long_press_ticks));
        ev_repeat = repeat_arm_1 && (CW'(repeat_1) >= CW'(cfg.repeat_ticks));

        raw_seen_next     = pin_level;
        settling_next     = settling_1 & ~fire;
        settle_count_next = settle_1;
        stable_next       = fire ? pin_level : stable_reg;
        long_armed_next   = long_arm_1 & ~ev_long;
        repeat_armed_next = repeat_arm_1;
        press_next        = press_1;
        repeat_next       = ev_repeat ? '0 : repeat_1;

        result.press_event       = ev_press;
        result.short_press_event = ev_short;
        result.release_event     = ev_release;
        result.long_press_event  = ev_long;
        result.repeat_event      = ev_repeat;
        result.stable_out        = stable_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_seen_reg     <= 1'b1;
            settling_reg     <= 1'b0;
            settle_count_reg <= '0;
            stable_reg       <= 1'b1;
            long_armed_reg   <= 1'b0;
            repeat_armed_reg <= 1'b0;
            press_reg        <= '0;
            repeat_reg       <= '0;
        end else if (step) begin
            raw_seen_reg     <= raw_seen_next;
            settling_reg     <= settling_next;
            settle_count_reg <= settle_count_next;
            stable_reg       <= stable_next;
            long_armed_reg   <= long_armed_next;
            repeat_armed_reg <= repeat_armed_next;
            press_reg        <= press_next;
            repeat_reg       <= repeat_next;
        end
    end

endmodule

// ===== sv/button_debounce_press_events_unit.sv =====
// Button debouncer with press, release, short-press, long-press and repeat events.
// Input channel (s_*): one raw active-low button sample per beat, one beat per
//   millisecond tick; every accepted beat yields exactly one result beat.
// Result channel (m_*): the event flags of that tick plus the debounced level.
// Config channel (cfg_*): always ready; index 0 debounce, 1 short limit,
//   2 long-press time, 3 repeat period; other indexes are dropped. Write only
//   while no result is outstanding.
// Each result is registered and presented on the cycle after its beat is accepted.
// Throughput: one beat per cycle. The whole step (timer increments, settle check,
//   event compares) is one pass of logic between the sample port and the
//   result register, so the only limit is the result register handshake.
// Stall: s_ready follows m_ready while a result is held; the block advances its
//   state only on an accepted beat, so a stalled receiver simply holds it.
// Reset (aresetn low, synchronous): the result register empties, the button is
//   taken as released, all timers and arming flags clear, and the settings
//   return to 15 / 1000 / 3000 / 200 ticks.
// TIMER_BITS sets the width of the saturating tick timers.
`include "assert_macros.svh"

module button_debounce_press_events_unit #(
    parameter int TIMER_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_pin_level,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_press_event,
    output logic                             m_short_press_event,
    output logic                             m_release_event,
    output logic                             m_long_press_event,
    output logic                             m_repeat_event,
    output logic                             m_stable_out,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bdpe_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [bdpe_pkg::CFG_W-1:0]       cfg_wdata
);

    bdpe_pkg::cfg_t    cfg_reg;
    bdpe_pkg::result_t step_result;
    bdpe_pkg::result_t out_reg;
    logic              m_valid_reg, m_valid_next;
    logic              accept;

    // Settings port never stalls.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks   <= bdpe_pkg::DEBOUNCE_RST;
            cfg_reg.short_max_ticks  <= bdpe_pkg::SHORT_MAX_RST;
            cfg_reg.long_press_ticks <= bdpe_pkg::LONG_RST;
            cfg_reg.repeat_ticks     <= bdpe_pkg::REPEAT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                bdpe_pkg::REG_DEBOUNCE:  cfg_reg.debounce_ticks   <= cfg_wdata;
                bdpe_pkg::REG_SHORT_MAX: cfg_reg.short_max_ticks  <= cfg_wdata;
                bdpe_pkg::REG_LONG:      cfg_reg.long_press_ticks <= cfg_wdata;
                bdpe_pkg::REG_REPEAT:    cfg_reg.repeat_ticks     <= cfg_wdata;
                default: ; // drop writes to unknown indexes
            endcase
        end
    end

    // Take a new sample whenever the result register is empty or being drained.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    bdpe_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (accept),
        .pin_level (s_pin_level),
        .cfg       (cfg_reg),
        .result    (step_result)
    );

    // Result register: fill on accept, empty when the receiver takes the beat.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload holds until the next accepted beat; no reset needed.
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= step_result;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_press_event       = out_reg.press_event;
    assign m_short_press_event = out_reg.short_press_event;
    assign m_release_event     = out_reg.release_event;
    assign m_long_press_event  = out_reg.long_press_event;
    assign m_repeat_event      = out_reg.repeat_event;
    assign m_stable_out        = out_reg.stable_out;

    // A press and a release can never resolve on the same tick.
    `ASSERT_ALWAYS(a_no_press_and_release, aclk, aresetn,
        !(m_valid && m_press_event && m_release_event))
    // A press event leaves the debounced level at pressed.
    `ASSERT_IMPLY(a_press_level, aclk, aresetn, m_valid && m_press_event, !m_stable_out)
    // A release event leaves the debounced level at released.
    `ASSERT_IMPLY(a_release_level, aclk, aresetn, m_valid && m_release_event, m_stable_out)
    // A short press is only ever reported together with its release.
    `ASSERT_IMPLY(a_short_with_release, aclk, aresetn,
        m_valid && m_short_press_event, m_release_event)

endmodule
